// ===== sv/hhp_pkg.sv =====
// Shared types and constants for the core hotplug hysteresis policy.
`default_nettype none

package hhp_pkg;

    localparam int FREQ_W  = 22;
    localparam int TIME_W  = 48;
    localparam int DELAY_W = 32;
    localparam int CNT_W   = 8;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_SET  = 2'd1,
        ACT_DOWN = 2'd2,
        ACT_UP   = 2'd3
    } t_action;

    typedef enum logic [0:0] {
        CMD_FREQ_REQ = 1'b0,
        CMD_HP_DONE  = 1'b1
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_UP_TASK_THR   = 3'd0,
        REG_DOWN_TASK_THR = 3'd1,
        REG_UP_CNT_THR    = 3'd2,
        REG_DOWN_CNT_THR  = 3'd3,
        REG_MIN_AFTER_UP  = 3'd4,
        REG_MIN_AFTER_DN  = 3'd5,
        REG_POLICY_EN     = 3'd6,
        REG_FREQ_THR      = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]   up_task_thr;
        logic [CNT_W-1:0]   down_task_thr;
        logic [CNT_W-1:0]   up_cnt_thr;
        logic [CNT_W-1:0]   down_cnt_thr;
        logic [DELAY_W-1:0] min_after_up;
        logic [DELAY_W-1:0] min_after_down;
        logic               policy_en;
        logic [FREQ_W-1:0]  freq_thr;
    } t_cfg;

    typedef struct packed {
        t_cmd              cmd;
        logic              cluster_is_big;
        logic              performance_mode;
        logic [FREQ_W-1:0] goal_freq;
        logic [FREQ_W-1:0] cur_freq;
        logic [FREQ_W-1:0] cap_freq;
        logic [CNT_W-1:0]  runnable_count;
        logic              boost;
        logic [TIME_W-1:0] now_us;
        logic              done_offline;
    } t_item;

    typedef struct packed {
        t_action           action;
        logic [FREQ_W-1:0] new_freq;
        logic [FREQ_W-1:0] old_freq;
        logic              cores_offline;
    } t_result;

    localparam logic [CNT_W-1:0]   RST_UP_TASK_THR   = 8'd3;
    localparam logic [CNT_W-1:0]   RST_DOWN_TASK_THR = 8'd3;
    localparam logic [CNT_W-1:0]   RST_UP_CNT_THR    = 8'd1;
    localparam logic [CNT_W-1:0]   RST_DOWN_CNT_THR  = 8'd6;
    localparam logic [DELAY_W-1:0] RST_MIN_AFTER_UP  = 32'd120000;
    localparam logic [DELAY_W-1:0] RST_MIN_AFTER_DN  = 32'd20000;
    localparam logic               RST_POLICY_EN     = 1'b0;
    localparam logic [FREQ_W-1:0]  RST_FREQ_THR      = 22'd2112000;

endpackage

`default_nettype wire

// ===== sv/hhp_cfg.sv =====
// Configuration register file for the hotplug policy.
`default_nettype none

module hhp_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_we,
    input  wire logic [hhp_pkg::IDX_W-1:0]   i_idx,
    input  wire logic [hhp_pkg::CFG_W-1:0]   i_data,
    output hhp_pkg::t_cfg                    o_cfg
);

    hhp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_task_thr    <= hhp_pkg::RST_UP_TASK_THR;
            r_cfg.down_task_thr  <= hhp_pkg::RST_DOWN_TASK_THR;
            r_cfg.up_cnt_thr     <= hhp_pkg::RST_UP_CNT_THR;
            r_cfg.down_cnt_thr   <= hhp_pkg::RST_DOWN_CNT_THR;
            r_cfg.min_after_up   <= hhp_pkg::RST_MIN_AFTER_UP;
            r_cfg.min_after_down <= hhp_pkg::RST_MIN_AFTER_DN;
            r_cfg.policy_en      <= hhp_pkg::RST_POLICY_EN;
            r_cfg.freq_thr       <= hhp_pkg::RST_FREQ_THR;
        end else if (i_we) begin
            unique case (hhp_pkg::t_reg_idx'(i_idx))
                hhp_pkg::REG_UP_TASK_THR:   r_cfg.up_task_thr    <= i_data[hhp_pkg::CNT_W-1:0];
                hhp_pkg::REG_DOWN_TASK_THR: r_cfg.down_task_thr  <= i_data[hhp_pkg::CNT_W-1:0];
                hhp_pkg::REG_UP_CNT_THR:    r_cfg.up_cnt_thr     <= i_data[hhp_pkg::CNT_W-1:0];
                hhp_pkg::REG_DOWN_CNT_THR:  r_cfg.down_cnt_thr   <= i_data[hhp_pkg::CNT_W-1:0];
                hhp_pkg::REG_MIN_AFTER_UP:  r_cfg.min_after_up   <= i_data[hhp_pkg::DELAY_W-1:0];
                hhp_pkg::REG_MIN_AFTER_DN:  r_cfg.min_after_down <= i_data[hhp_pkg::DELAY_W-1:0];
                hhp_pkg::REG_POLICY_EN:     r_cfg.policy_en      <= i_data[0];
                hhp_pkg::REG_FREQ_THR:      r_cfg.freq_thr       <= i_data[hhp_pkg::FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/hhp_policy.sv =====
// Policy state registers and the per-word decision logic.
`default_nettype none

module hhp_policy (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire hhp_pkg::t_item i_item,
    input  wire hhp_pkg::t_cfg  i_cfg,
    output hhp_pkg::t_result o_res
);

    logic                        r_offline, n_offline;
    logic                        r_busy, n_busy;
    logic [hhp_pkg::CNT_W-1:0]   r_up_cnt, n_up_cnt;
    logic [hhp_pkg::CNT_W-1:0]   r_dn_cnt, n_dn_cnt;
    logic [hhp_pkg::TIME_W-1:0]  r_up_stamp, n_up_stamp;
    logic [hhp_pkg::TIME_W-1:0]  r_dn_stamp, n_dn_stamp;

    logic [hhp_pkg::TIME_W-1:0]  stamp_sel;
    logic [hhp_pkg::DELAY_W-1:0] delay_sel;
    logic [hhp_pkg::TIME_W:0]    elapsed;
    logic                        waiting;
    logic [hhp_pkg::CNT_W-1:0]   up_bumped, dn_bumped;
    logic                        do_set, clamp;
    logic [hhp_pkg::FREQ_W-1:0]  pick_freq;
    hhp_pkg::t_result            res;

    // Up path only runs offline (dwell after down), down path only online.
    assign stamp_sel = r_offline ? r_dn_stamp : r_up_stamp;
    assign delay_sel = r_offline ? i_cfg.min_after_down : i_cfg.min_after_up;
    assign elapsed   = {1'b0, i_item.now_us} - {1'b0, stamp_sel};
    assign waiting   = elapsed[hhp_pkg::TIME_W] ||
                       (elapsed[hhp_pkg::TIME_W-1:0] <
                        {{(hhp_pkg::TIME_W-hhp_pkg::DELAY_W){1'b0}}, delay_sel});

    assign up_bumped = (r_up_cnt == hhp_pkg::CNT_MAX) ? r_up_cnt : r_up_cnt + 1'b1;
    assign dn_bumped = (r_dn_cnt == hhp_pkg::CNT_MAX) ? r_dn_cnt : r_dn_cnt + 1'b1;

    always_comb begin
        n_offline  = r_offline;
        n_busy     = r_busy;
        n_up_cnt   = r_up_cnt;
        n_dn_cnt   = r_dn_cnt;
        n_up_stamp = r_up_stamp;
        n_dn_stamp = r_dn_stamp;
        do_set     = 1'b0;
        clamp      = 1'b0;
        res.action   = hhp_pkg::ACT_NONE;
        res.new_freq = '0;
        res.old_freq = '0;

        priority if (i_item.cmd == hhp_pkg::CMD_HP_DONE) begin
            n_busy    = 1'b0;
            n_offline = i_item.done_offline;
            if (i_item.done_offline) begin
                n_dn_stamp = i_item.now_us;
            end else begin
                n_up_stamp = i_item.now_us;
            end
        end else if (!i_item.cluster_is_big || !i_cfg.policy_en) begin
            do_set = 1'b1;
        end else if (i_item.performance_mode) begin
            do_set = 1'b1;
            clamp  = 1'b1;
        end else if (r_busy) begin
            // hotplug in flight: hold everything
        end else if ((i_item.runnable_count > i_cfg.up_task_thr) || i_item.boost) begin
            if (!r_offline) begin
                n_up_cnt = '0;
                n_dn_cnt = '0;
                do_set   = 1'b1;
                clamp    = 1'b1;
            end else begin
                n_up_cnt = up_bumped;
                if ((up_bumped < i_cfg.up_cnt_thr) || waiting) begin
                    do_set = 1'b1;
                end else begin
                    n_up_cnt     = '0;
                    n_dn_cnt     = '0;
                    res.action   = hhp_pkg::ACT_UP;
                    res.new_freq = i_cfg.freq_thr;
                    res.old_freq = i_item.cur_freq;
                    n_busy       = 1'b1;
                end
            end
        end else if (i_item.runnable_count < i_cfg.down_task_thr) begin
            if (r_offline) begin
                n_up_cnt = '0;
                n_dn_cnt = '0;
                do_set   = 1'b1;
            end else begin
                n_dn_cnt = dn_bumped;
                if ((dn_bumped < i_cfg.down_cnt_thr) || waiting) begin
                    do_set = 1'b1;
                    clamp  = 1'b1;
                end else begin
                    n_up_cnt     = '0;
                    n_dn_cnt     = '0;
                    res.action   = hhp_pkg::ACT_DOWN;
                    res.new_freq = i_item.cap_freq;
                    res.old_freq = i_item.cur_freq;
                    n_busy       = 1'b1;
                end
            end
        end else begin
            n_up_cnt = '0;
            n_dn_cnt = '0;
            do_set   = 1'b1;
            clamp    = !r_offline;
        end

        pick_freq = (clamp && (i_item.goal_freq > i_cfg.freq_thr)) ?
                    i_cfg.freq_thr : i_item.goal_freq;
        // drop a set that would not change the frequency
        if (do_set && (pick_freq != i_item.cur_freq)) begin
            res.action   = hhp_pkg::ACT_SET;
            res.new_freq = pick_freq;
            res.old_freq = i_item.cur_freq;
        end
        res.cores_offline = n_offline;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offline  <= 1'b0;
            r_busy     <= 1'b0;
            r_up_cnt   <= '0;
            r_dn_cnt   <= '0;
            r_up_stamp <= '0;
            r_dn_stamp <= '0;
        end else if (i_fire) begin
            r_offline  <= n_offline;
            r_busy     <= n_busy;
            r_up_cnt   <= n_up_cnt;
            r_dn_cnt   <= n_dn_cnt;
            r_up_stamp <= n_up_stamp;
            r_dn_stamp <= n_dn_stamp;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

// ===== sv/core_hotplug_hysteresis_policy.sv =====
// Top level: input register, policy decision, result register, config port.
// Each word is decided in the input register; its result is then held in the result register.
// Throughput: one word per cycle unless stalled; input and result registers part the channels.
// The decision for each word is one pass of compares and a 49-bit subtract on the input register.
// Reset (synchronous, active low) empties both registers, clears the policy state and
// loads the configuration defaults.
`default_nettype none

module core_hotplug_hysteresis_policy (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_cmd,
    input  wire logic                              i_cluster_is_big,
    input  wire logic                              i_performance_mode,
    input  wire logic [hhp_pkg::FREQ_W-1:0]        i_goal_freq,
    input  wire logic [hhp_pkg::FREQ_W-1:0]        i_cur_freq,
    input  wire logic [hhp_pkg::FREQ_W-1:0]        i_cap_freq,
    input  wire logic [hhp_pkg::CNT_W-1:0]         i_runnable_count,
    input  wire logic                              i_boost,
    input  wire logic [hhp_pkg::TIME_W-1:0]        i_now_us,
    input  wire logic                              i_done_offline,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [1:0]                             o_action,
    output logic [hhp_pkg::FREQ_W-1:0]             o_new_freq,
    output logic [hhp_pkg::FREQ_W-1:0]             o_old_freq,
    output logic                                   o_cores_offline,
    input  wire logic                              i_cfg_we,
    input  wire logic [hhp_pkg::IDX_W-1:0]         i_cfg_idx,
    input  wire logic [hhp_pkg::CFG_W-1:0]         i_cfg_data
);

    hhp_pkg::t_cfg    cfg;
    hhp_pkg::t_item   r_in;
    logic             r_in_valid;
    hhp_pkg::t_result r_out, res;
    logic             r_out_valid;
    logic             out_free, fire, in_take;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    hhp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    hhp_policy u_policy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.cmd              <= hhp_pkg::t_cmd'(i_cmd);
            r_in.cluster_is_big   <= i_cluster_is_big;
            r_in.performance_mode <= i_performance_mode;
            r_in.goal_freq        <= i_goal_freq;
            r_in.cur_freq         <= i_cur_freq;
            r_in.cap_freq         <= i_cap_freq;
            r_in.runnable_count   <= i_runnable_count;
            r_in.boost            <= i_boost;
            r_in.now_us           <= i_now_us;
            r_in.done_offline     <= i_done_offline;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_action        = r_out.action;
    assign o_new_freq      = r_out.new_freq;
    assign o_old_freq      = r_out.old_freq;
    assign o_cores_offline = r_out.cores_offline;

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == hhp_pkg::ACT_NONE)) |-> (o_new_freq == '0 && o_old_freq == '0))
        else $error("none result carries a frequency");

    a_set_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == hhp_pkg::ACT_SET)) |-> (o_new_freq != o_old_freq))
        else $error("set result does not change the frequency");

    a_up_offline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == hhp_pkg::ACT_UP)) |-> o_cores_offline)
        else $error("cores up requested while online");

    a_down_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == hhp_pkg::ACT_DOWN)) |-> !o_cores_offline)
        else $error("cores down requested while offline");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
